FILE: hw/rtl/seg_pkg.sv
// ---------------------------------------------------------------------------
// seg_pkg
// Shared types and register indexes of the segment intersection block.
// ---------------------------------------------------------------------------
package seg_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REF_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_END_Y   = 2'd3;

  // result flags and quotient signs that travel down the pipeline
  typedef struct packed {
    logic hit;
    logic pv;
    logic neg_x;
    logic neg_y;
  } seg_flags_t;

endpackage

FILE: hw/rtl/seg_geom.sv
// ---------------------------------------------------------------------------
// seg_geom
// Orientation tests, line equations and crossing numerators in six stages.
// ---------------------------------------------------------------------------
module seg_geom #(
  parameter int unsigned W   = 16,
  parameter int unsigned NW  = 3 * W + 4,
  parameter int unsigned DTW = 2 * W + 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] p1x_i,
  input  logic signed [W-1:0] p1y_i,
  input  logic signed [W-1:0] q1x_i,
  input  logic signed [W-1:0] q1y_i,
  input  logic signed [W-1:0] p2x_i,
  input  logic signed [W-1:0] p2y_i,
  input  logic signed [W-1:0] q2x_i,
  input  logic signed [W-1:0] q2y_i,
  output logic                valid_o,
  output seg_pkg::seg_flags_t flags_o,
  output logic [NW-1:0]       num_x_o,
  output logic [NW-1:0]       num_y_o,
  output logic [DTW-1:0]      den_o
);

  localparam int unsigned DW = W + 1;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned OW = 2 * W + 3;
  localparam int unsigned LW = 2 * W + 3;
  localparam int unsigned HW = 2 * W + 2;

  function automatic logic btw(logic signed [W-1:0] a, logic signed [W-1:0] m,
                               logic signed [W-1:0] b);
    btw = ((a <= m) && (m <= b)) || ((b <= m) && (m <= a));
  endfunction

  // ---- stage A: differences and box tests
  logic                 va_q;
  logic signed [DW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [DW-1:0] e1x_q, e1y_q, e2x_q, e2y_q, e3x_q, e3y_q, e4x_q, e4y_q;
  logic signed [W-1:0]  pa1x_q, pa1y_q, pa2x_q, pa2y_q;
  logic [3:0]           boxa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= DW'(q1y_i) - DW'(p1y_i);
    b1_q   <= DW'(p1x_i) - DW'(q1x_i);
    a2_q   <= DW'(q2y_i) - DW'(p2y_i);
    b2_q   <= DW'(p2x_i) - DW'(q2x_i);
    e1x_q  <= DW'(p2x_i) - DW'(q1x_i);
    e1y_q  <= DW'(p2y_i) - DW'(q1y_i);
    e2x_q  <= DW'(q2x_i) - DW'(q1x_i);
    e2y_q  <= DW'(q2y_i) - DW'(q1y_i);
    e3x_q  <= DW'(p1x_i) - DW'(q2x_i);
    e3y_q  <= DW'(p1y_i) - DW'(q2y_i);
    e4x_q  <= DW'(q1x_i) - DW'(q2x_i);
    e4y_q  <= DW'(q1y_i) - DW'(q2y_i);
    pa1x_q <= p1x_i;
    pa1y_q <= p1y_i;
    pa2x_q <= p2x_i;
    pa2y_q <= p2y_i;
    boxa_q[0] <= btw(p1x_i, p2x_i, q1x_i) && btw(p1y_i, p2y_i, q1y_i);
    boxa_q[1] <= btw(p1x_i, q2x_i, q1x_i) && btw(p1y_i, q2y_i, q1y_i);
    boxa_q[2] <= btw(p2x_i, p1x_i, q2x_i) && btw(p2y_i, p1y_i, q2y_i);
    boxa_q[3] <= btw(p2x_i, q1x_i, q2x_i) && btw(p2y_i, q1y_i, q2y_i);
  end

  // ---- stage B: products
  logic                 vb_q;
  logic signed [PW-1:0] t1a_q, t1b_q, t2a_q, t2b_q, t3a_q, t3b_q, t4a_q, t4b_q;
  logic signed [PW-1:0] m1_q, m2_q, m3_q, m4_q, d1_q, d2_q;
  logic signed [DW-1:0] a1b_q, b1b_q, a2b_q, b2b_q;
  logic [3:0]           boxb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1a_q  <= PW'(a1_q) * PW'(e1x_q);
    t1b_q  <= PW'(b1_q) * PW'(e1y_q);
    t2a_q  <= PW'(a1_q) * PW'(e2x_q);
    t2b_q  <= PW'(b1_q) * PW'(e2y_q);
    t3a_q  <= PW'(a2_q) * PW'(e3x_q);
    t3b_q  <= PW'(b2_q) * PW'(e3y_q);
    t4a_q  <= PW'(a2_q) * PW'(e4x_q);
    t4b_q  <= PW'(b2_q) * PW'(e4y_q);
    m1_q   <= PW'(a1_q) * PW'(pa1x_q);
    m2_q   <= PW'(b1_q) * PW'(pa1y_q);
    m3_q   <= PW'(a2_q) * PW'(pa2x_q);
    m4_q   <= PW'(b2_q) * PW'(pa2y_q);
    d1_q   <= PW'(a1_q) * PW'(b2_q);
    d2_q   <= PW'(a2_q) * PW'(b1_q);
    a1b_q  <= a1_q;
    b1b_q  <= b1_q;
    a2b_q  <= a2_q;
    b2b_q  <= b2_q;
    boxb_q <= boxa_q;
  end

  // ---- stage C: orientation signs, line constants, determinant
  logic signed [OW-1:0] o1, o2, o3, o4;
  assign o1 = OW'(t1a_q) + OW'(t1b_q);
  assign o2 = OW'(t2a_q) + OW'(t2b_q);
  assign o3 = OW'(t3a_q) + OW'(t3b_q);
  assign o4 = OW'(t4a_q) + OW'(t4b_q);

  logic                  vc_q;
  logic [1:0]            s1_q, s2_q, s3_q, s4_q;   // {negative, zero}
  logic signed [PW-1:0]  c1_q, c2_q;
  logic signed [DTW-1:0] detc_q;
  logic signed [DW-1:0]  a1c_q, b1c_q, a2c_q, b2c_q;
  logic [3:0]            boxc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= {o1[OW-1], o1 == '0};
    s2_q   <= {o2[OW-1], o2 == '0};
    s3_q   <= {o3[OW-1], o3 == '0};
    s4_q   <= {o4[OW-1], o4 == '0};
    c1_q   <= m1_q + m2_q;
    c2_q   <= m3_q + m4_q;
    detc_q <= DTW'(d1_q) - DTW'(d2_q);
    a1c_q  <= a1b_q;
    b1c_q  <= b1b_q;
    a2c_q  <= a2b_q;
    b2c_q  <= b2b_q;
    boxc_q <= boxb_q;
  end

  // ---- stage D: split products of the numerators, branch decision
  logic signed [W+1:0] c1l, c2l;
  logic signed [W:0]   c1h, c2h;
  assign c1l = $signed({1'b0, c1_q[W:0]});
  assign c2l = $signed({1'b0, c2_q[W:0]});
  assign c1h = $signed(c1_q[PW-1:W+1]);
  assign c2h = $signed(c2_q[PW-1:W+1]);

  logic                  vd_q, cand_q, coll_q;
  logic signed [HW-1:0]  xh1_q, xh2_q, yh1_q, yh2_q;
  logic signed [LW-1:0]  xl1_q, xl2_q, yl1_q, yl2_q;
  logic signed [DTW-1:0] detd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xh1_q  <= HW'(b2c_q) * HW'(c1h);
    xl1_q  <= LW'(b2c_q) * LW'(c1l);
    xh2_q  <= HW'(b1c_q) * HW'(c2h);
    xl2_q  <= LW'(b1c_q) * LW'(c2l);
    yh1_q  <= HW'(a1c_q) * HW'(c2h);
    yl1_q  <= LW'(a1c_q) * LW'(c2l);
    yh2_q  <= HW'(a2c_q) * HW'(c1h);
    yl2_q  <= LW'(a2c_q) * LW'(c1l);
    detd_q <= detc_q;
    cand_q <= (s1_q != s2_q) && (s3_q != s4_q);
    coll_q <= (s1_q[0] && boxc_q[0]) || (s2_q[0] && boxc_q[1])
           || (s3_q[0] && boxc_q[2]) || (s4_q[0] && boxc_q[3]);
  end

  // ---- stage E: combine partial products
  function automatic logic signed [NW-1:0] join_pp(logic signed [HW-1:0] hi,
                                                   logic signed [LW-1:0] lo);
    logic signed [NW-1:0] hs;
    hs = NW'($signed({hi, {(W + 1){1'b0}}}));
    join_pp = hs + NW'(lo);
  endfunction

  logic                  ve_q, pv_e_q, coll_e_q;
  logic signed [NW-1:0]  nx_q, ny_q;
  logic signed [DTW-1:0] dete_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q     <= join_pp(xh1_q, xl1_q) - join_pp(xh2_q, xl2_q);
    ny_q     <= join_pp(yh1_q, yl1_q) - join_pp(yh2_q, yl2_q);
    dete_q   <= detd_q;
    pv_e_q   <= cand_q && (detd_q != '0);
    coll_e_q <= coll_q;
  end

  // ---- stage F: magnitudes and quotient signs
  logic                vf_q;
  seg_pkg::seg_flags_t flf_q;
  logic [NW-1:0]       nxa_q, nya_q;
  logic [DTW-1:0]      dena_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nxa_q       <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
    nya_q       <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
    dena_q      <= dete_q[DTW-1] ? DTW'(-dete_q) : DTW'(dete_q);
    flf_q.pv    <= pv_e_q;
    flf_q.hit   <= pv_e_q || coll_e_q;
    flf_q.neg_x <= nx_q[NW-1] ^ dete_q[DTW-1];
    flf_q.neg_y <= ny_q[NW-1] ^ dete_q[DTW-1];
  end

  assign valid_o = vf_q;
  assign flags_o = flf_q;
  assign num_x_o = nxa_q;
  assign num_y_o = nya_q;
  assign den_o   = dena_q;

endmodule

FILE: hw/rtl/seg_div.sv
// ---------------------------------------------------------------------------
// seg_div
// Pipelined restoring divider, one quotient bit per stage, for x and y.
// ---------------------------------------------------------------------------
module seg_div #(
  parameter int unsigned W   = 16,
  parameter int unsigned NW  = 3 * W + 4,
  parameter int unsigned DTW = 2 * W + 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  seg_pkg::seg_flags_t flags_i,
  input  logic [NW-1:0]       num_x_i,
  input  logic [NW-1:0]       num_y_i,
  input  logic [DTW-1:0]      den_i,
  output logic                valid_o,
  output seg_pkg::seg_flags_t flags_o,
  output logic [W-1:0]        quo_x_o,
  output logic [W-1:0]        quo_y_o
);

  logic                vv [0:W];
  seg_pkg::seg_flags_t fl [0:W];
  logic [NW-1:0]       rx [0:W];
  logic [NW-1:0]       ry [0:W];
  logic [DTW-1:0]      dd [0:W];
  logic [W-1:0]        qx [0:W];
  logic [W-1:0]        qy [0:W];

  assign vv[0] = valid_i;
  assign fl[0] = flags_i;
  assign rx[0] = num_x_i;
  assign ry[0] = num_y_i;
  assign dd[0] = den_i;
  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int unsigned BIT = W - 1 - k;
    logic [NW-1:0] sh;
    logic          gex, gey;
    assign sh  = NW'(dd[k]) << BIT;
    assign gex = rx[k] >= sh;
    assign gey = ry[k] >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vv[k+1] <= 1'b0;
      end else begin
        vv[k+1] <= vv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      fl[k+1] <= fl[k];
      dd[k+1] <= dd[k];
      rx[k+1] <= gex ? rx[k] - sh : rx[k];
      ry[k+1] <= gey ? ry[k] - sh : ry[k];
      qx[k+1] <= qx[k] | (W'(gex) << BIT);
      qy[k+1] <= qy[k] | (W'(gey) << BIT);
    end
  end

  assign valid_o = vv[W];
  assign flags_o = fl[W];
  assign quo_x_o = qx[W];
  assign quo_y_o = qy[W];

endmodule

FILE: hw/rtl/segment_intersection.sv
// ---------------------------------------------------------------------------
// segment_intersection
// Query segment against a configured reference segment, one word per cycle.
// ---------------------------------------------------------------------------
// Pipeline from start to done: six geometry stages, one divider stage per
//   quotient bit, one output register.
// Throughput: one word per cycle, set by the fully pipelined divider; busy_o
//   stays low.
// Reset: clears the reference registers to zero and drops all words in flight.
// The receiver cannot stall: each result shows on done_o for one cycle.
module segment_intersection #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] query_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] query_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] query_end_y_i,
  input  logic                          cfg_we_i,
  input  logic [seg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          point_valid_o,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic signed [COORD_WIDTH-1:0] cross_y_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned NW  = 3 * W + 4;   // crossing numerator
  localparam int unsigned DTW = 2 * W + 3;   // determinant

  // Reference endpoints; the user must write them only while no word is in flight; the block does not enforce this.
  logic signed [W-1:0] ref_sx_q, ref_sy_q, ref_ex_q, ref_ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_sx_q <= '0;
      ref_sy_q <= '0;
      ref_ex_q <= '0;
      ref_ey_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        seg_pkg::REG_REF_START_X: ref_sx_q <= $signed(cfg_data_i);
        seg_pkg::REG_REF_START_Y: ref_sy_q <= $signed(cfg_data_i);
        seg_pkg::REG_REF_END_X:   ref_ex_q <= $signed(cfg_data_i);
        seg_pkg::REG_REF_END_Y:   ref_ey_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The pipeline never holds, so a new word is taken every cycle.
  assign busy_o = 1'b0;

  logic                g_valid;
  seg_pkg::seg_flags_t g_flags;
  logic [NW-1:0]       g_num_x, g_num_y;
  logic [DTW-1:0]      g_den;

  // Orientation signs, box tests, determinant and numerators.
  seg_geom #(.W(W), .NW(NW), .DTW(DTW)) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .p1x_i   (query_start_x_i),
    .p1y_i   (query_start_y_i),
    .q1x_i   (query_end_x_i),
    .q1y_i   (query_end_y_i),
    .p2x_i   (ref_sx_q),
    .p2y_i   (ref_sy_q),
    .q2x_i   (ref_ex_q),
    .q2y_i   (ref_ey_q),
    .valid_o (g_valid),
    .flags_o (g_flags),
    .num_x_o (g_num_x),
    .num_y_o (g_num_y),
    .den_o   (g_den)
  );

  logic                d_valid;
  seg_pkg::seg_flags_t d_flags;
  logic [W-1:0]        d_qx, d_qy;

  // Magnitude quotients; the crossing lies inside both segments, so the
  // quotient fits in W bits. A zero divisor only occurs with pv clear.
  seg_div #(.W(W), .NW(NW), .DTW(DTW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (g_valid),
    .flags_i (g_flags),
    .num_x_i (g_num_x),
    .num_y_i (g_num_y),
    .den_i   (g_den),
    .valid_o (d_valid),
    .flags_o (d_flags),
    .quo_x_o (d_qx),
    .quo_y_o (d_qy)
  );

  // Restore the sign (truncation toward zero) and drop the point when no
  // proper crossing was found.
  logic [W-1:0] x_d, y_d;
  assign x_d = !d_flags.pv ? '0 : (d_flags.neg_x ? W'(-d_qx) : d_qx);
  assign y_d = !d_flags.pv ? '0 : (d_flags.neg_y ? W'(-d_qy) : d_qy);

  logic         done_q, hit_q, pv_q;
  logic [W-1:0] x_q, y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= d_flags.hit;
    pv_q  <= d_flags.pv;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign point_valid_o = pv_q;
  assign cross_x_o     = $signed(x_q);
  assign cross_y_o     = $signed(y_q);

endmodule
